// ----- src/deq_pkg.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue package
// Shared codes, widths and controller/datapath handshake types.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF  = 16;
  localparam int DATA_W     = 32;
  localparam int HELD_W     = 5;
  localparam int S_TDATA_W  = 40;
  localparam int M_TDATA_W  = 40;

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;    // capture the request fields
    logic exec;     // carry out the request on the ring
    logic capture;  // take the read data as the popped value
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_read;  // the request is a successful pop
  } stat_t;

endpackage

`default_nettype wire

// ----- src/deq_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/deq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one request at a time: accept, execute, optional read, deliver.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  wire logic          m_tready,
  output deq_pkg::cmd_t      cmd,
  input  wire deq_pkg::stat_t stat
);

  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      s_tready <= 1'b1;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid && s_tready) begin
            state    <= S_EXEC;
            s_tready <= 1'b0;
          end
        end
        S_EXEC: begin
          if (stat.need_read) begin
            state <= S_READ;
          end else begin
            state    <= S_OUT;
            m_tvalid <= 1'b1;
          end
        end
        S_READ: begin
          state    <= S_OUT;
          m_tvalid <= 1'b1;
        end
        S_OUT: begin
          if (m_tready) begin
            state    <= S_IDLE;
            m_tvalid <= 1'b0;
            s_tready <= 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign cmd.latch   = s_tvalid && s_tready;
  assign cmd.exec    = (state == S_EXEC);
  assign cmd.capture = (state == S_READ);

  // The block never takes a request while a result is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("input ready while a result is pending");

endmodule

`default_nettype wire

// ----- src/deq_dpath.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Ring storage, front index, entry count and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_dpath #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire deq_pkg::cmd_t                 cmd,
  output deq_pkg::stat_t                     stat,
  input  wire logic [1:0]                    op,
  input  wire logic signed [deq_pkg::DATA_W-1:0] push_value,
  output logic [1:0]                         status,
  output logic                               popped_valid,
  output logic signed [deq_pkg::DATA_W-1:0]  popped_value,
  output logic [deq_pkg::HELD_W-1:0]         entries_held
);

  import deq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0]   DEPTH_SUM = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_IDX  = AW'(DEPTH - 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

  op_t              op_q;
  logic [DATA_W-1:0] value_q;
  logic [AW-1:0]    front;
  logic [AW-1:0]    front_next;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    cnt_next;
  logic [AW:0]      end_sum;
  logic [AW:0]      back_sum;
  logic [AW-1:0]    back_pos;
  logic [AW-1:0]    last_pos;
  logic [AW-1:0]    front_dec;
  logic [AW-1:0]    front_inc;
  logic             full;
  logic             empty;
  logic             we;
  logic [AW-1:0]    waddr;
  logic             re;
  logic [AW-1:0]    raddr;
  logic [DATA_W-1:0] rdata;
  logic [1:0]       status_next;
  logic             pop_ok;
  logic [31:0]      cnt_wide;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q    <= op_t'(op);
      value_q <= push_value;
    end
  end

  assign full  = (cnt == DEPTH_CNT);
  assign empty = (cnt == '0);

  // Ring positions: sums stay below twice the depth, so one compare wraps.
  assign end_sum   = {1'b0, front} + (AW + 1)'(cnt);
  assign back_pos  = (end_sum >= DEPTH_SUM) ? AW'(end_sum - DEPTH_SUM) : AW'(end_sum);
  assign back_sum  = end_sum - (AW + 1)'(1);
  assign last_pos  = (back_sum >= DEPTH_SUM) ? AW'(back_sum - DEPTH_SUM) : AW'(back_sum);
  assign front_dec = (front == '0) ? LAST_IDX : front - AW'(1);
  assign front_inc = (front == LAST_IDX) ? '0 : front + AW'(1);

  always_comb begin
    front_next  = front;
    cnt_next    = cnt;
    we          = 1'b0;
    waddr       = back_pos;
    re          = 1'b0;
    raddr       = front;
    status_next = STATUS_DONE;
    pop_ok      = 1'b0;
    unique case (op_q)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          front_next = front_dec;
          waddr      = front_dec;
          we         = 1'b1;
          cnt_next   = cnt + CW'(1);
        end
      end
      OP_PUSH_BACK: begin
        if (full) begin
          status_next = STATUS_FULL;
        end else begin
          waddr    = back_pos;
          we       = 1'b1;
          cnt_next = cnt + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          raddr      = front;
          re         = 1'b1;
          pop_ok     = 1'b1;
          front_next = front_inc;
          cnt_next   = cnt - CW'(1);
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          status_next = STATUS_EMPTY;
        end else begin
          raddr    = last_pos;
          re       = 1'b1;
          pop_ok   = 1'b1;
          cnt_next = cnt - CW'(1);
        end
      end
      default: begin
        status_next = STATUS_DONE;
      end
    endcase
  end

  assign stat.need_read = pop_ok;

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we && cmd.exec),
    .waddr (waddr),
    .wdata (value_q),
    .re    (re && cmd.exec),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      cnt   <= '0;
    end else if (cmd.exec) begin
      front <= front_next;
      cnt   <= cnt_next;
    end
  end

  assign cnt_wide = 32'(cnt_next);

  // Result register; the popped value follows from the RAM in the next cycle.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status       <= status_next;
      popped_valid <= pop_ok;
      popped_value <= '0;
      entries_held <= cnt_wide[HELD_W-1:0];
    end else if (cmd.capture) begin
      popped_value <= rdata;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= DEPTH_CNT)
    else $error("entry count exceeds depth");

  a_front_bound: assert property (@(posedge clk) disable iff (rst)
    front <= LAST_IDX)
    else $error("front index outside the ring");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && !$past(cmd.exec) |-> $stable(cnt) && $stable(front))
    else $error("queue state moved without an executed request");

endmodule

`default_nettype wire

// ----- src/double_ended_queue_top.sv -----
// A push gives its result after the execute state; a pop goes through the execute
// and read states. One request is in flight at a time: the block takes no new
// request until the result is taken, as set by the controller sequence and the
// registered read of the single-read-port ring RAM.
// Synchronous reset empties the queue; ring contents are not cleared.
// ----------------------------------------------------------------------------
// Double-ended queue top level
// Bounded ring deque with push/pop at both ends over stream interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_queue_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // [1:0] op, [33:2] push_value, [39:34] zero
  input  wire logic [deq_pkg::S_TDATA_W-1:0] s_tdata,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [1:0] status, [2] popped_valid, [34:3] popped_value, [39:35] entries_held
  output logic [deq_pkg::M_TDATA_W-1:0]      m_tdata
);

  import deq_pkg::*;

  cmd_t               cmd;
  stat_t              stat;
  logic [1:0]         status;
  logic               popped_valid;
  logic [DATA_W-1:0]  popped_value;
  logic [HELD_W-1:0]  entries_held;

  deq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  deq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (s_tdata[1:0]),
    .push_value   (s_tdata[33:2]),
    .status       (status),
    .popped_valid (popped_valid),
    .popped_value (popped_value),
    .entries_held (entries_held)
  );

  assign m_tdata = {entries_held, popped_value, popped_valid, status};

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push and pop requests at both ends of the ring through the input
// stream and checks every result against the directed table or a behavioral
// copy of the deque. A short directed table covers the empty and full cases
// and extreme values. A long random run follows, biased in phases toward
// filling, draining or churning, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb;
  import deq_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 1200;
  localparam int QUIET_ITEMS  = 200;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_REPORTS  = 10;
  localparam bit CHECKED      = 1'b1;
  localparam bit PREDICTED    = 1'b0;

  typedef struct packed {
    logic [1:0]  status;
    logic        valid;
    logic [31:0] value;
    logic [4:0]  held;
  } deq_result_t;

  typedef struct {
    op_t         op;
    logic [31:0] value;
    int          reps;
    bit          typed;
    deq_result_t res;
  } stim_row_t;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b1;
  logic [M_TDATA_W-1:0] m_tdata;

  // Behavioral copy of the ring.
  logic [31:0] ring_model [DEPTH];
  int          head_slot  = 0;
  int          held_count = 0;

  deq_result_t pending_results [$];
  stim_row_t   stim_table [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          rx_stall_left = 0;
  bit          rx_quiet = 1'b0;

  double_ended_queue_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic deq_result_t apply_request(op_t op, logic [31:0] val);
    deq_result_t r;
    int          slot;
    r = '0;
    r.status = STATUS_DONE;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      if (held_count >= DEPTH) begin
        r.status = STATUS_FULL;
      end else begin
        if (op == OP_PUSH_FRONT) begin
          head_slot = (head_slot + DEPTH - 1) % DEPTH;
          slot = head_slot;
        end else begin
          slot = (head_slot + held_count) % DEPTH;
        end
        ring_model[slot] = val;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        if (op == OP_POP_FRONT) begin
          slot = head_slot;
          head_slot = (head_slot + 1) % DEPTH;
        end else begin
          slot = (head_slot + held_count - 1) % DEPTH;
        end
        r.valid = 1'b1;
        r.value = ring_model[slot];
        held_count--;
      end
    end
    r.held = 5'(held_count);
    return r;
  endfunction

  task automatic table_row(op_t op, logic [31:0] val, int reps, bit typed,
                           logic [1:0] status, logic valid, logic [31:0] pval,
                           logic [4:0] held);
    stim_row_t row;
    row.op         = op;
    row.value      = val;
    row.reps       = reps;
    row.typed      = typed;
    row.res.status = status;
    row.res.valid  = valid;
    row.res.value  = pval;
    row.res.held   = held;
    stim_table.push_back(row);
  endtask

  // Called right after a rising edge; returns at the edge of the transaction.
  task automatic issue_request(op_t op, logic [31:0] val, bit typed,
                               deq_result_t typed_res);
    deq_result_t pred;
    if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, val, op};
    do @(posedge clk); while (!s_tready);
    pred = apply_request(op, val);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Output stream: random stall bursts, none once the quiet stretch begins.
  always @(posedge clk) begin
    if (rx_quiet) begin
      m_tready <= 1'b1;
    end else if (rx_stall_left != 0) begin
      rx_stall_left <= rx_stall_left - 1;
      m_tready <= 1'b0;
    end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
      rx_stall_left <= $urandom_range(0, 15);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got.status = m_tdata[1:0];
      got.valid  = m_tdata[2];
      got.value  = m_tdata[34:3];
      got.held   = m_tdata[39:35];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("Unexpected result: status %0d valid %0d value %h held %0d",
                   got.status, got.valid, got.value, got.held);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.valid !== want.valid ||
            got.value !== want.value || got.held !== want.held) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("Mismatch: expected status %0d valid %0d value %h held %0d, %s",
                     want.status, want.valid, want.value, want.held,
                     $sformatf("got status %0d valid %0d value %h held %0d",
                               got.status, got.valid, got.value, got.held));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    deq_result_t none;
    op_t         op;
    int          seg_left;
    int          push_bias;
    none     = '0;
    seg_left = 0;
    push_bias = 50;

    // Directed table: empty and full boundaries, single-entry pops, extremes.
    table_row(OP_POP_FRONT,  32'h0,         1, CHECKED, STATUS_EMPTY, 1'b0, 32'h0, 5'd0);
    table_row(OP_POP_BACK,   32'hFFFF_FFFF, 1, CHECKED, STATUS_EMPTY, 1'b0, 32'h0, 5'd0);
    table_row(OP_PUSH_FRONT, 32'h7FFF_FFFF, 1, CHECKED, STATUS_DONE, 1'b0, 32'h0, 5'd1);
    table_row(OP_POP_BACK,   32'h0,         1, CHECKED, STATUS_DONE, 1'b1, 32'h7FFF_FFFF, 5'd0);
    table_row(OP_PUSH_BACK,  32'h8000_0000, 1, CHECKED, STATUS_DONE, 1'b0, 32'h0, 5'd1);
    table_row(OP_POP_FRONT,  32'h0,         1, CHECKED, STATUS_DONE, 1'b1, 32'h8000_0000, 5'd0);
    table_row(OP_PUSH_BACK,  32'hFFFF_FFFF, 1, CHECKED, STATUS_DONE, 1'b0, 32'h0, 5'd1);
    table_row(OP_PUSH_FRONT, 32'h0,         1, CHECKED, STATUS_DONE, 1'b0, 32'h0, 5'd2);
    table_row(OP_POP_BACK,   32'h0,         1, CHECKED, STATUS_DONE, 1'b1, 32'hFFFF_FFFF, 5'd1);
    table_row(OP_POP_BACK,   32'h0,         1, CHECKED, STATUS_DONE, 1'b1, 32'h0, 5'd0);
    table_row(OP_PUSH_FRONT, 32'h5555_5555, 8, PREDICTED, STATUS_DONE, 1'b0, 32'h0, 5'd0);
    table_row(OP_PUSH_BACK,  32'hAAAA_AAAA, 8, PREDICTED, STATUS_DONE, 1'b0, 32'h0, 5'd0);
    table_row(OP_PUSH_FRONT, 32'h1234_5678, 1, CHECKED, STATUS_FULL, 1'b0, 32'h0, 5'd16);
    table_row(OP_PUSH_BACK,  32'h7FFF_FFFF, 1, CHECKED, STATUS_FULL, 1'b0, 32'h0, 5'd16);
    table_row(OP_POP_FRONT,  32'h0,         1, PREDICTED, STATUS_DONE, 1'b0, 32'h0, 5'd0);
    table_row(OP_PUSH_BACK,  32'h8000_0000, 1, CHECKED, STATUS_DONE, 1'b0, 32'h0, 5'd16);
    table_row(OP_POP_BACK,   32'h0,         1, CHECKED, STATUS_DONE, 1'b1, 32'h8000_0000, 5'd15);
    table_row(OP_POP_FRONT,  32'h0,        15, PREDICTED, STATUS_DONE, 1'b0, 32'h0, 5'd0);
    table_row(OP_POP_BACK,   32'h0,         1, CHECKED, STATUS_EMPTY, 1'b0, 32'h0, 5'd0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[i]) begin
      for (int r = 0; r < stim_table[i].reps; r++)
        issue_request(stim_table[i].op, stim_table[i].value + r, stim_table[i].typed,
                      stim_table[i].res);
    end
    wait_drained();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) begin
        // Hold the input until every outstanding result has been taken.
        wait_drained();
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) begin
        tx_idle_pct = 0;
        rx_quiet <= 1'b1;
      end
      if (seg_left == 0) begin
        // Each phase leans toward filling, draining or churning the queue.
        seg_left = $urandom_range(8, 48);
        case ($urandom_range(0, 2))
          0: push_bias = 15;
          1: push_bias = 50;
          default: push_bias = 85;
        endcase
        if (n < RANDOM_ITEMS - QUIET_ITEMS) begin
          case ($urandom_range(0, 2))
            0: tx_idle_pct = 0;
            1: tx_idle_pct = 10;
            default: tx_idle_pct = 40;
          endcase
          case ($urandom_range(0, 2))
            0: rx_stall_pct <= 0;
            1: rx_stall_pct <= 15;
            default: rx_stall_pct <= 50;
          endcase
        end
      end
      seg_left--;
      if ($urandom_range(0, 99) < push_bias)
        op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
      else
        op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
      issue_request(op, pick_value(), PREDICTED, none);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dpath.sv
src/double_ended_queue_top.sv
tb/tb.sv
